// ----- src/lzw_pkg.sv -----
// Shared types and constants for the 12-bit LZW compressor.
package lzw_pkg;

  localparam int CODE_W     = 12;
  localparam int BYTE_W     = 8;
  localparam int NIB_W      = 4;
  localparam int BASE_CODES = 256;
  localparam int MAX_BYTES  = 4;
  localparam int NCNT_W     = 3;

  typedef struct packed {
    logic [BYTE_W-1:0] in_byte;
    logic              in_last;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              run_last;
    logic              stream_end;
  } out_item_t;

  typedef struct packed {
    logic [CODE_W-1:0] prefix;
    logic [BYTE_W-1:0] byte_val;
  } dict_entry_t;

  typedef struct packed {
    logic              a_vld;
    logic [CODE_W-1:0] a_code;
    logic              b_vld;
    logic [CODE_W-1:0] b_code;
  } emit_req_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } lzw_state_t;

endpackage

// ----- src/lzw_dict.sv -----
// Dictionary memory: one write port, one registered read port.
module lzw_dict #(
  parameter int DEPTH = 3840,
  localparam int IDX_W = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 rd_en,
  input  logic [IDX_W-1:0]     rd_addr,
  output lzw_pkg::dict_entry_t rd_data,
  input  logic                 wr_en,
  input  logic [IDX_W-1:0]     wr_addr,
  input  lzw_pkg::dict_entry_t wr_data
);
  import lzw_pkg::*;

  dict_entry_t mem [DEPTH];
  dict_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- src/lzw_emit.sv -----
// Code packer: turns up to two codes into bytes and streams them through the output register.
module lzw_emit (
  input  logic               clk,
  input  logic               rst_n,
  input  lzw_pkg::emit_req_t req,
  output logic               busy,
  output logic               out_valid,
  input  logic               out_stall,
  output lzw_pkg::out_item_t out_data
);
  import lzw_pkg::*;

  logic [BYTE_W-1:0] buf_r   [MAX_BYTES];
  logic [BYTE_W-1:0] buf_nxt [MAX_BYTES];
  logic [NCNT_W-1:0] cnt_r;
  logic [NCNT_W-1:0] cnt_nxt;
  logic [1:0]        idx_r;
  logic              busy_r;
  logic              end_r;
  logic              nib_pend_r;
  logic              nib_pend_nxt;
  logic [NIB_W-1:0]  nib_r;
  logic [NIB_W-1:0]  nib_nxt;
  logic              out_valid_r;
  out_item_t         out_data_r;
  logic              load_go;
  logic              pop;
  logic              last_pop;

  always_comb begin
    nib_pend_nxt = nib_pend_r;
    nib_nxt      = nib_r;
    cnt_nxt      = '0;
    for (int i = 0; i < MAX_BYTES; i++) begin
      buf_nxt[i] = '0;
    end
    if (req.a_vld) begin
      if (!nib_pend_nxt) begin
        buf_nxt[cnt_nxt[1:0]] = req.a_code[CODE_W-1:NIB_W];
        cnt_nxt               = cnt_nxt + NCNT_W'(1);
        nib_nxt               = req.a_code[NIB_W-1:0];
        nib_pend_nxt          = 1'b1;
      end else begin
        buf_nxt[cnt_nxt[1:0]]         = {nib_nxt, req.a_code[CODE_W-1:BYTE_W]};
        buf_nxt[cnt_nxt[1:0] + 2'd1]  = req.a_code[BYTE_W-1:0];
        cnt_nxt                       = cnt_nxt + NCNT_W'(2);
        nib_nxt                       = '0;
        nib_pend_nxt                  = 1'b0;
      end
    end
    if (req.b_vld) begin
      if (!nib_pend_nxt) begin
        buf_nxt[cnt_nxt[1:0]] = req.b_code[CODE_W-1:NIB_W];
        cnt_nxt               = cnt_nxt + NCNT_W'(1);
        nib_nxt               = req.b_code[NIB_W-1:0];
        nib_pend_nxt          = 1'b1;
      end else begin
        buf_nxt[cnt_nxt[1:0]]         = {nib_nxt, req.b_code[CODE_W-1:BYTE_W]};
        buf_nxt[cnt_nxt[1:0] + 2'd1]  = req.b_code[BYTE_W-1:0];
        cnt_nxt                       = cnt_nxt + NCNT_W'(2);
        nib_nxt                       = '0;
        nib_pend_nxt                  = 1'b0;
      end
      if (nib_pend_nxt) begin
        buf_nxt[cnt_nxt[1:0]] = {nib_nxt, {NIB_W{1'b0}}};
        cnt_nxt               = cnt_nxt + NCNT_W'(1);
      end
      nib_nxt      = '0;
      nib_pend_nxt = 1'b0;
    end
  end

  assign load_go  = (req.a_vld || req.b_vld) && !busy_r;
  assign pop      = busy_r && (!out_valid_r || !out_stall);
  assign last_pop = ({1'b0, idx_r} + NCNT_W'(1)) == cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      nib_pend_r  <= 1'b0;
      nib_r       <= '0;
      idx_r       <= '0;
      cnt_r       <= '0;
      end_r       <= 1'b0;
    end else begin
      if (pop) begin
        out_valid_r <= 1'b1;
        idx_r       <= idx_r + 2'd1;
        if (last_pop) begin
          busy_r <= 1'b0;
        end
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (load_go) begin
        cnt_r      <= cnt_nxt;
        idx_r      <= '0;
        busy_r     <= (cnt_nxt != '0);
        end_r      <= req.b_vld;
        nib_pend_r <= nib_pend_nxt;
        nib_r      <= nib_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_go) begin
      buf_r <= buf_nxt;
    end
    if (pop) begin
      out_data_r.out_byte   <= buf_r[idx_r];
      out_data_r.run_last   <= last_pop;
      out_data_r.stream_end <= last_pop && end_r;
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- src/lzw_compressor_12bit.sv -----
// Top level of the 12-bit LZW compressor.
// One input byte is taken at a time. The first byte of a stream is taken
// without a search; every later byte searches the dictionary memory one entry
// per cycle in code order, through its single read port, and stops at the first
// matching entry. A miss emits the prefix code and adds an entry while there is
// room; at most DICT_ENTRIES-256 entries are added in a stream. The 12-bit codes
// leave as bytes, two codes in three bytes, most significant bits first, one
// byte per output transfer; the next input byte is taken once the bytes of the
// previous one have entered the output register. A stream ends with the byte
// flagged last: the final code and any half byte are flushed and the
// dictionary starts empty for the next stream. No clearing pass is needed.
module lzw_compressor_12bit #(
  parameter int DICT_ENTRIES = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  lzw_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output lzw_pkg::out_item_t out_data
);
  import lzw_pkg::*;

  localparam int DEPTH = DICT_ENTRIES - BASE_CODES;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  lzw_state_t        state_r, state_nxt;
  logic [CODE_W-1:0] prefix_r, prefix_nxt;
  logic              have_r, have_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [BYTE_W-1:0] byte_r, byte_nxt;
  logic              last_r, last_nxt;
  logic [CNT_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic              cmp_pend_r, cmp_pend_nxt;
  logic [IDX_W-1:0]  cmp_idx_r, cmp_idx_nxt;

  logic              in_xfer;
  logic              emit_busy;
  logic              done;
  logic [CODE_W-1:0] new_prefix;
  logic              rd_en;
  logic              wr_en;
  dict_entry_t       rd_data;
  dict_entry_t       wr_data;
  emit_req_t         req;

  assign in_stall = !(state_r == ST_IDLE && !emit_busy);
  assign in_xfer  = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer && have_r) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    prefix_nxt   = prefix_r;
    have_nxt     = have_r;
    count_nxt    = count_r;
    byte_nxt     = byte_r;
    last_nxt     = last_r;
    rd_idx_nxt   = rd_idx_r;
    cmp_pend_nxt = cmp_pend_r;
    cmp_idx_nxt  = cmp_idx_r;
    req          = '0;
    rd_en        = 1'b0;
    wr_en        = 1'b0;
    wr_data      = '{prefix: prefix_r, byte_val: byte_r};
    done         = 1'b0;
    new_prefix   = prefix_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          byte_nxt     = in_data.in_byte;
          last_nxt     = in_data.in_last;
          rd_idx_nxt   = '0;
          cmp_pend_nxt = 1'b0;
          if (!have_r) begin
            prefix_nxt = CODE_W'(in_data.in_byte);
            have_nxt   = 1'b1;
            if (in_data.in_last) begin
              req.b_vld  = 1'b1;
              req.b_code = CODE_W'(in_data.in_byte);
              prefix_nxt = '0;
              have_nxt   = 1'b0;
              count_nxt  = '0;
            end
          end
        end
      end
      ST_SCAN: begin
        if (rd_idx_r < count_r) begin
          rd_en        = 1'b1;
          rd_idx_nxt   = rd_idx_r + CNT_W'(1);
          cmp_pend_nxt = 1'b1;
          cmp_idx_nxt  = rd_idx_r[IDX_W-1:0];
        end else begin
          cmp_pend_nxt = 1'b0;
        end
        if (cmp_pend_r && rd_data.prefix == prefix_r && rd_data.byte_val == byte_r) begin
          done       = 1'b1;
          new_prefix = CODE_W'(BASE_CODES) + CODE_W'(cmp_idx_r);
        end else if (!cmp_pend_r && rd_idx_r >= count_r) begin
          done       = 1'b1;
          new_prefix = CODE_W'(byte_r);
          req.a_vld  = 1'b1;
          req.a_code = prefix_r;
          if (count_r < CNT_W'(DEPTH)) begin
            wr_en     = 1'b1;
            count_nxt = count_r + CNT_W'(1);
          end
        end
        if (done) begin
          cmp_pend_nxt = 1'b0;
          prefix_nxt   = new_prefix;
          if (last_r) begin
            req.b_vld  = 1'b1;
            req.b_code = new_prefix;
            prefix_nxt = '0;
            have_nxt   = 1'b0;
            count_nxt  = '0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      prefix_r   <= '0;
      have_r     <= 1'b0;
      count_r    <= '0;
      rd_idx_r   <= '0;
      cmp_pend_r <= 1'b0;
      cmp_idx_r  <= '0;
      last_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      prefix_r   <= prefix_nxt;
      have_r     <= have_nxt;
      count_r    <= count_nxt;
      rd_idx_r   <= rd_idx_nxt;
      cmp_pend_r <= cmp_pend_nxt;
      cmp_idx_r  <= cmp_idx_nxt;
      last_r     <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

  lzw_dict #(
    .DEPTH(DEPTH)
  ) u_dict (
    .clk    (clk),
    .rd_en  (rd_en),
    .rd_addr(rd_idx_r[IDX_W-1:0]),
    .rd_data(rd_data),
    .wr_en  (wr_en),
    .wr_addr(count_r[IDX_W-1:0]),
    .wr_data(wr_data)
  );

  lzw_emit u_emit (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (req),
    .busy     (emit_busy),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

// ----- verif/lzw_compressor_12bit_tb.sv -----
// Self-checking testbench for the 12-bit LZW compressor with a byte-level scoreboard.
`timescale 1ns / 1ps

class lzw_code_checker #(int DICT = 512);
  lzw_pkg::out_item_t expected_bytes[$];
  lzw_pkg::out_item_t burst[$];
  logic [11:0] prefix;
  bit          have_prefix;
  logic [12:0] free_code;
  logic [11:0] ent_prefix [DICT-256];
  logic [7:0]  ent_char [DICT-256];
  bit          nib_pend;
  logic [3:0]  nib;
  int errors;
  int items;
  int results;
  int streams;
  int hits;
  int dropped_adds;

  function new();
    clear_stream();
    errors = 0;
    items = 0;
    results = 0;
    streams = 0;
    hits = 0;
    dropped_adds = 0;
  endfunction

  function void clear_stream();
    prefix = '0;
    have_prefix = 1'b0;
    free_code = 13'd256;
    nib_pend = 1'b0;
    nib = '0;
  endfunction

  function void push_out(logic [7:0] b);
    lzw_pkg::out_item_t o;
    o.out_byte = b;
    o.run_last = 1'b0;
    o.stream_end = 1'b0;
    burst.push_back(o);
  endfunction

  function void pack_code(logic [11:0] code);
    if (!nib_pend) begin
      push_out(code[11:4]);
      nib = code[3:0];
      nib_pend = 1'b1;
    end else begin
      push_out({nib, code[11:8]});
      push_out(code[7:0]);
      nib = '0;
      nib_pend = 1'b0;
    end
  endfunction

  function void take_input_byte(lzw_pkg::in_item_t it);
    int hit;
    int idx;
    lzw_pkg::out_item_t o;
    items++;
    burst.delete();
    if (!have_prefix) begin
      prefix = {4'd0, it.in_byte};
      have_prefix = 1'b1;
    end else begin
      hit = -1;
      for (int c = 256; c < free_code && c < DICT; c++) begin
        if (hit < 0 && ent_prefix[c-256] == prefix && ent_char[c-256] == it.in_byte)
          hit = c;
      end
      if (hit >= 0) begin
        prefix = hit[11:0];
        hits++;
      end else begin
        pack_code(prefix);
        if (free_code < DICT) begin
          ent_prefix[free_code-256] = prefix;
          ent_char[free_code-256] = it.in_byte;
          free_code++;
        end else begin
          dropped_adds++;
        end
        prefix = {4'd0, it.in_byte};
      end
    end
    if (it.in_last) begin
      pack_code(prefix);
      if (nib_pend)
        push_out({nib, 4'd0});
      idx = burst.size() - 1;
      o = burst[idx];
      o.stream_end = 1'b1;
      burst[idx] = o;
      clear_stream();
      streams++;
    end
    if (burst.size() > 0) begin
      idx = burst.size() - 1;
      o = burst[idx];
      o.run_last = 1'b1;
      burst[idx] = o;
    end
    foreach (burst[i])
      expected_bytes.push_back(burst[i]);
  endfunction

  function void check_output_byte(lzw_pkg::out_item_t got);
    lzw_pkg::out_item_t want;
    results++;
    if (expected_bytes.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected output byte %02h run_last %0b stream_end %0b",
                 got.out_byte, got.run_last, got.stream_end);
      return;
    end
    want = expected_bytes.pop_front();
    if (got.out_byte !== want.out_byte || got.run_last !== want.run_last ||
        got.stream_end !== want.stream_end) begin
      errors++;
      if (errors <= 10)
        $display("mismatch at output %0d: expected %02h/%0b/%0b got %02h/%0b/%0b",
                 results, want.out_byte, want.run_last, want.stream_end,
                 got.out_byte, got.run_last, got.stream_end);
    end
  endfunction
endclass

module lzw_compressor_12bit_tb;
  localparam int DICT_CODES  = 512;
  localparam int STALL_LIMIT = 5000;

  typedef logic [7:0] byte_seq_t[$];

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  lzw_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_stall;
  lzw_pkg::out_item_t out_data;

  lzw_code_checker #(DICT_CODES) sb;
  bit steady;
  int quiet_cycles;

  lzw_compressor_12bit #(.DICT_ENTRIES(DICT_CODES)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  function automatic bit take_break();
    return !steady && ($urandom_range(99, 0) < 23);
  endfunction

  always @(posedge clk) begin
    out_stall <= take_break();
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        sb.take_input_byte(in_data);
      if (out_valid && !out_stall)
        sb.check_output_byte(out_data);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    @(posedge clk);
    while (quiet_cycles < STALL_LIMIT)
      @(posedge clk);
    $display("timeout after %0d cycles without a transfer", STALL_LIMIT);
    $display("status: fail");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    while (take_break()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{in_byte: b, in_last: last};
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_stream(input byte_seq_t s);
    for (int i = 0; i < s.size(); i++)
      send_byte(s[i], i == s.size() - 1);
  endtask

  task automatic wait_for_codes();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_bytes.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    byte_seq_t s;
    int sent;
    int len;
    int nsym;
    logic [7:0] alpha [4];
    sb = new();
    steady = 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    s = '{8'h00};
    send_stream(s);
    s = '{8'hFF, 8'hFF};
    send_stream(s);
    s = '{8'h41, 8'h41, 8'h41, 8'h41, 8'h41, 8'h41, 8'h41};
    send_stream(s);
    s = '{8'h00, 8'h01, 8'h00, 8'h01, 8'h00, 8'h01, 8'h80, 8'h7F, 8'h55, 8'hAA};
    send_stream(s);
    wait_for_codes();

    sent = 0;
    while (sent < 120) begin
      steady = (sent >= 50 && sent < 85);
      len = $urandom_range(12, 1);
      nsym = $urandom_range(1, 0) ? $urandom_range(4, 2) : 0;
      foreach (alpha[k])
        alpha[k] = 8'($urandom_range(255, 0));
      s.delete();
      for (int i = 0; i < len; i++)
        s.push_back(nsym > 0 ? alpha[$urandom_range(nsym - 1, 0)] : 8'($urandom_range(255, 0)));
      send_stream(s);
      sent += len;
    end
    steady = 1'b0;
    wait_for_codes();
    repeat (300) @(posedge clk);

    $display("covered %0d input bytes in %0d streams, %0d packed output bytes checked",
             sb.items, sb.streams, sb.results);
    $display("%0d dictionary hits, %0d new phrases dropped with a full dictionary",
             sb.hits, sb.dropped_adds);
    if (sb.errors == 0 && sb.expected_bytes.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d output bytes never seen",
               sb.errors, sb.expected_bytes.size());
      $display("status: fail");
    end
    $finish;
  end
endmodule
